@@ sv/loop_transport_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Loop transport controller assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LOOP_TRANSPORT_CONTROLLER_DEFINES_SVH
`define LOOP_TRANSPORT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Check prop on every rising edge, masked while reset is high.
`define LTC_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// Check prop on every rising edge, reset included.
`define LTC_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`else

`define LTC_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define LTC_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

@@ sv/ltc_pkg.sv @@
// ----------------------------------------------------------------------------
// Loop transport controller package
// Event and command codes, field widths and the word types shared by modules.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int FIELD_W    = 3;
  localparam int SLOT_OUT_W = 10;
  localparam int MASK_W     = 7;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 48;

  // Event kinds
  localparam logic [FIELD_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [FIELD_W-1:0] MODE_RECORD = 3'd1;
  localparam logic [FIELD_W-1:0] MODE_STOP   = 3'd2;
  localparam logic [FIELD_W-1:0] MODE_REMOTE = 3'd3;
  localparam logic [FIELD_W-1:0] MODE_SELECT = 3'd4;

  // Remote commands
  localparam logic [FIELD_W-1:0] CMD_RECORD  = 3'd0;
  localparam logic [FIELD_W-1:0] CMD_PLAY    = 3'd1;
  localparam logic [FIELD_W-1:0] CMD_OVERDUB = 3'd2;
  localparam logic [FIELD_W-1:0] CMD_STOP    = 3'd3;
  localparam logic [FIELD_W-1:0] CMD_CLEAR   = 3'd4;

  // Button index that selects nothing
  localparam logic [FIELD_W-1:0] BUTTON_NONE = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] mode;
    logic [FIELD_W-1:0] command;
    logic [FIELD_W-1:0] button;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]    transport_state;
    logic [SLOT_OUT_W-1:0] play_position;
    logic                  record_strobe;
    logic [SLOT_OUT_W-1:0] record_slot;
    logic [SLOT_OUT_W-1:0] loop_length;
    logic [MASK_W-1:0]     changed_mask;
  } result_t;

endpackage

@@ sv/loop_transport_controller.sv @@
// ----------------------------------------------------------------------------
// Loop transport controller
// Clock-synced looper transport: record, play, overdub and stop on events.
// ----------------------------------------------------------------------------
//
//  channel  dir  word                              per word
//  -------  ---  --------------------------------  ----------------------
//  s_*      in   event: kind, remote cmd, button   one event
//  m_*      out  state, slots, strobe, mask        one result per event
//
// One event enters per cycle while s_tready is high. It is held in the input
// register, then the transport logic updates state and loads the result
// register, from which the result word is offered on m_*.
// The rate is set by the single state update in ltc_transport; the two
// registers keep both sides flowing.
// Reset (rst, synchronous) empties both registers and returns the transport
// to empty with all slot counters and the mask at zero. A stalled m_tready
// holds the result and, once the input register is full too, drops s_tready.
// ----------------------------------------------------------------------------
`include "loop_transport_controller_defines.svh"

module loop_transport_controller #(
  parameter int SLOTS   = 1024,
  parameter int QUANTUM = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] command, [5:3] button, [7:6] zero
  input  logic [ltc_pkg::S_TDATA_W-1:0]   s_tdata,
  // [2:0] mode
  input  logic [ltc_pkg::FIELD_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [2:0] transport_state, [12:3] play_position, [13] record_strobe,
  // [23:14] record_slot, [33:24] loop_length, [40:34] changed_mask, [47:41] zero
  output logic [ltc_pkg::M_TDATA_W-1:0]   m_tdata
);
  import ltc_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t step_result;

  // Move the held event into the transport when the result slot frees up
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.mode    <= s_tuser;
      in_item.command <= s_tdata[2:0];
      in_item.button  <= s_tdata[5:3];
    end
  end

  ltc_transport #(
    .SLOTS   (SLOTS),
    .QUANTUM (QUANTUM)
  ) u_transport (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (step_result)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'b0, step_result.changed_mask, step_result.loop_length,
                  step_result.record_slot, step_result.record_strobe,
                  step_result.play_position, step_result.transport_state};
    end
  end

  `LTC_ASSERT(a_stall_only_when_full, clk, rst, !s_tready |-> in_valid && m_tvalid && !m_tready, "input stalled with room left")
  `LTC_ASSERT(a_held_event_kept, clk, rst, in_valid && !advance |=> in_valid && $stable(in_item), "held event lost or changed")
  `LTC_ASSERT(a_advance_fills_output, clk, rst, advance |=> m_tvalid, "stepped event produced no result")

endmodule

@@ sv/ltc_transport.sv @@
// ----------------------------------------------------------------------------
// Loop transport state machine
// Holds transport state, slot counters and the touched mask; one event a step.
// ----------------------------------------------------------------------------
`include "loop_transport_controller_defines.svh"

module ltc_transport #(
  parameter int SLOTS   = 1024,
  parameter int QUANTUM = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  ltc_pkg::item_t  item,
  output ltc_pkg::result_t result
);
  import ltc_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int QW = (QUANTUM > 1) ? $clog2(QUANTUM) : 1;
  localparam int EW = SW + SLOT_OUT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [QW-1:0] Q_LAST    = QW'(QUANTUM - 1);

  typedef enum logic [2:0] {
    ST_EMPTY     = 3'd0,
    ST_REC_WAIT  = 3'd1,
    ST_REC       = 3'd2,
    ST_PLAY_WAIT = 3'd3,
    ST_PLAY      = 3'd4,
    ST_DUB       = 3'd5,
    ST_STOPPED   = 3'd6
  } state_t;

  state_t            state, state_next;
  logic [SW-1:0]     rec_slot, rec_slot_next;
  logic [QW-1:0]     rec_phase, rec_phase_next;   // rec_slot modulo QUANTUM
  logic [SW-1:0]     play_slot, play_slot_next;
  logic [QW-1:0]     play_phase, play_phase_next; // play_slot modulo QUANTUM
  logic [SW-1:0]     length_slots, length_slots_next;
  logic [MASK_W-1:0] touched_mask, touched_mask_next;

  logic          strobe;
  logic [SW-1:0] written;

  // Play advance: play_slot stays below length_slots, so one compare wraps it
  logic [SW:0]   play_inc;
  logic          play_wrap;
  logic [SW-1:0] adv_slot;
  logic [QW-1:0] adv_phase;

  // Frame write from the current (or zeroed) record slot
  logic [SW-1:0] wf_base;
  logic [QW-1:0] wf_base_phase;
  logic          wf_full;
  logic [SW-1:0] wf_slot;
  logic [QW-1:0] wf_phase;

  always_comb begin
    play_inc  = {1'b0, play_slot} + 1'b1;
    play_wrap = (length_slots == '0) || (play_inc == {1'b0, length_slots});
    adv_slot  = play_wrap ? '0 : play_inc[SW-1:0];
    if (play_wrap || play_phase == Q_LAST) begin
      adv_phase = '0;
    end else begin
      adv_phase = play_phase + 1'b1;
    end

    wf_base       = (state == ST_REC_WAIT) ? '0 : rec_slot;
    wf_base_phase = (state == ST_REC_WAIT) ? '0 : rec_phase;
    wf_full       = (wf_base == LAST_SLOT);
    if (wf_full) begin
      wf_slot  = wf_base;
      wf_phase = wf_base_phase;
    end else begin
      wf_slot  = wf_base + 1'b1;
      wf_phase = (wf_base_phase == Q_LAST) ? '0 : wf_base_phase + 1'b1;
    end
  end

  always_comb begin
    state_next        = state;
    rec_slot_next     = rec_slot;
    rec_phase_next    = rec_phase;
    play_slot_next    = play_slot;
    play_phase_next   = play_phase;
    length_slots_next = length_slots;
    touched_mask_next = touched_mask;
    strobe            = 1'b0;
    written           = rec_slot;

    unique case (item.mode)
      MODE_TICK: begin
        case (state)
          ST_REC_WAIT, ST_REC, ST_PLAY_WAIT: begin
            strobe         = 1'b1;
            written        = wf_base;
            rec_slot_next  = wf_slot;
            rec_phase_next = wf_phase;
            if (wf_full) begin
              state_next = ST_PLAY_WAIT;
            end else if (state == ST_REC_WAIT) begin
              state_next = ST_REC;
            end
            // Close the take on a quantize boundary
            if (state == ST_PLAY_WAIT && wf_phase == '0) begin
              play_slot_next    = '0;
              play_phase_next   = '0;
              length_slots_next = wf_slot;
              state_next        = ST_PLAY;
            end
          end
          ST_PLAY: begin
            play_slot_next  = adv_slot;
            play_phase_next = adv_phase;
          end
          ST_DUB: begin
            rec_slot_next   = play_slot;
            rec_phase_next  = play_phase;
            play_slot_next  = adv_slot;
            play_phase_next = adv_phase;
          end
          default: begin
          end
        endcase
      end
      MODE_RECORD: begin
        unique case (state)
          ST_EMPTY: begin
            touched_mask_next = '0;
            state_next        = ST_REC_WAIT;
          end
          ST_PLAY:             state_next = ST_DUB;
          ST_REC:              state_next = ST_PLAY_WAIT;
          ST_DUB, ST_STOPPED:  state_next = ST_PLAY;
          default: begin
          end
        endcase
      end
      MODE_STOP: begin
        if (state == ST_PLAY || state == ST_PLAY_WAIT || state == ST_DUB) begin
          state_next = ST_STOPPED;
        end else begin
          state_next = ST_EMPTY;
        end
      end
      MODE_REMOTE: begin
        unique case (item.command)
          CMD_RECORD: begin
            touched_mask_next = '0;
            state_next        = ST_REC_WAIT;
          end
          CMD_PLAY: begin
            if (state == ST_REC) begin
              state_next = ST_PLAY_WAIT;
            end else if (state == ST_DUB || state == ST_STOPPED) begin
              state_next = ST_PLAY;
            end
          end
          CMD_OVERDUB: state_next = ST_DUB;
          CMD_STOP:    state_next = ST_STOPPED;
          CMD_CLEAR:   state_next = ST_EMPTY;
          default: begin
          end
        endcase
      end
      MODE_SELECT: begin
        if ((state == ST_REC || state == ST_DUB) && item.button != BUTTON_NONE) begin
          touched_mask_next = touched_mask | (MASK_W'(1) << item.button);
        end
      end
      default: begin
      end
    endcase
  end

  // Widen or trim slot values to the 10-bit result fields
  logic [EW-1:0] play_ext, slot_ext, len_ext;

  always_comb begin
    play_ext = EW'(play_slot_next);
    slot_ext = strobe ? EW'(written) : EW'(rec_slot_next);
    len_ext  = EW'(length_slots_next);

    result.transport_state = state_next;
    result.play_position   = play_ext[SLOT_OUT_W-1:0];
    result.record_strobe   = strobe;
    result.record_slot     = slot_ext[SLOT_OUT_W-1:0];
    result.loop_length     = len_ext[SLOT_OUT_W-1:0];
    result.changed_mask    = touched_mask_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_EMPTY;
      rec_slot     <= '0;
      rec_phase    <= '0;
      play_slot    <= '0;
      play_phase   <= '0;
      length_slots <= '0;
      touched_mask <= '0;
    end else if (step) begin
      state        <= state_next;
      rec_slot     <= rec_slot_next;
      rec_phase    <= rec_phase_next;
      play_slot    <= play_slot_next;
      play_phase   <= play_phase_next;
      length_slots <= length_slots_next;
      touched_mask <= touched_mask_next;
    end
  end

  `LTC_ASSERT(a_play_inside_loop, clk, rst, (play_slot < length_slots) || (play_slot == '0), "play position outside loop")
  `LTC_ASSERT(a_rec_tick_advances, clk, rst, step && item.mode == MODE_TICK && state == ST_REC && rec_slot != LAST_SLOT |=> rec_slot == $past(rec_slot) + 1'b1, "record slot did not advance")
  `LTC_ASSERT(a_take_close, clk, rst, step && item.mode == MODE_TICK && state == ST_PLAY_WAIT && state_next == ST_PLAY |=> play_slot == '0 && length_slots == rec_slot, "loop capture inconsistent")

endmodule
